// ===== sv/fcl_pkg.sv =====
// shared types, widths and constants for the chunk frustum cull / lod select block
// no dependencies; imported by every module of the block
package fcl_pkg;

   localparam int CHUNKS_PER_SIDE = 64;
   localparam int FRAC_BITS = 4;

   localparam int NUM_PLANES = 6;
   // doubled unit normal (Q1.14) as a shift
   localparam int NORM2_SHIFT = 15;

   localparam int IDX_W = 6;
   localparam int CENTER_W = 24;
   localparam int PROD_W = 40;
   localparam int RAD_W = 33;
   localparam int SUM_W = 44;
   localparam int DIFF_W = 25;
   localparam int SQ_W = 49;
   localparam int SQSUM_W = 51;

   typedef enum logic [2:0] {
      CSR_PLANE_LEFT   = 3'd0,
      CSR_PLANE_TOP    = 3'd1,
      CSR_PLANE_RIGHT  = 3'd2,
      CSR_PLANE_BOTTOM = 3'd3,
      CSR_PLANE_NEAR   = 3'd4,
      CSR_PLANE_FAR    = 3'd5,
      CSR_CAMERA_XZ    = 3'd6,
      CSR_CHUNK_GEOM   = 3'd7
   } csr_index_type;

   typedef enum logic [1:0] {
      LOD_CULLED  = 2'd0,
      LOD_FULL    = 2'd1,
      LOD_HALF    = 2'd2,
      LOD_QUARTER = 2'd3
   } lod_type;

   // load strobes for the product stage and the compare stage
   typedef struct packed {
      logic adv2;
      logic adv3;
   } fcl_adv_type;

   // doubled chunk center along one axis: (2*idx+1)*s - 2*o
   function automatic logic signed [CENTER_W-1:0] fcl_center2(
      input logic [IDX_W-1:0] idx,
      input logic [15:0] s,
      input logic [15:0] o
   );
      logic [22:0] prod;
      logic signed [CENTER_W-1:0] span;
      logic signed [CENTER_W-1:0] offs;
      prod = 23'({idx, 1'b1}) * 23'(s);
      span = $signed(CENTER_W'(prod));
      offs = $signed(CENTER_W'({o, 1'b0}));
      return span - offs;
   endfunction

   function automatic logic [16:0] fcl_abs16(input logic signed [15:0] v);
      logic signed [16:0] w;
      w = 17'(v);
      return w[16] ? 17'(-w) : 17'(w);
   endfunction

endpackage

// ===== sv/fcl_plane_unit.sv =====
// one frustum plane test: products in stage 2, sum and compare in stage 3
// depends on fcl_pkg
module fcl_plane_unit #(
   parameter int FRAC_BITS = fcl_pkg::FRAC_BITS
) (
   input  logic                            clock,
   input  fcl_pkg::fcl_adv_type            adv,
   input  logic [63:0]                     plane,
   input  logic [15:0]                     chunk_size,
   input  logic signed [fcl_pkg::CENTER_W-1:0] cx2,
   input  logic signed [fcl_pkg::CENTER_W-1:0] cz2,
   output logic                            cull
);
   import fcl_pkg::*;

   // doubled vertical half extent (200 world units)
   localparam logic [15:0] EY2 = 16'(200 << FRAC_BITS);

   logic signed [15:0] nx, ny, nz, dd;
   logic [16:0] abs_nx, abs_ny, abs_nz;

   logic signed [PROD_W-1:0] px_in, px_ff, pz_in, pz_ff;
   logic signed [30:0] pd_in, pd_ff;
   logic [RAD_W-1:0] rx_in, rx_ff, ry_in, ry_ff, rz_in, rz_ff;
   logic signed [SUM_W-1:0] sum_w, thr_w;
   logic cull_in, cull_ff;

   assign nx = $signed(plane[15:0]);
   assign ny = $signed(plane[31:16]);
   assign nz = $signed(plane[47:32]);
   assign dd = $signed(plane[63:48]);

   assign abs_nx = fcl_abs16(nx);
   assign abs_ny = fcl_abs16(ny);
   assign abs_nz = fcl_abs16(nz);

   assign px_in = PROD_W'(nx) * PROD_W'(cx2);
   assign pz_in = PROD_W'(nz) * PROD_W'(cz2);
   assign pd_in = $signed({dd, 15'b0});
   assign rx_in = RAD_W'(chunk_size) * RAD_W'(abs_nx);
   assign ry_in = RAD_W'(EY2) * RAD_W'(abs_ny);
   assign rz_in = RAD_W'(chunk_size) * RAD_W'(abs_nz);

   always_ff @(posedge clock) begin
      if (adv.adv2) begin
         px_ff <= px_in;
         pz_ff <= pz_in;
         pd_ff <= pd_in;
         rx_ff <= rx_in;
         ry_ff <= ry_in;
         rz_ff <= rz_in;
      end
   end

   // signed distance plus projected radius, all doubled
   assign sum_w = $signed(SUM_W'(px_ff)) + $signed(SUM_W'(pz_ff)) + $signed(SUM_W'(pd_ff))
                + $signed(SUM_W'(rx_ff)) + $signed(SUM_W'(ry_ff)) + $signed(SUM_W'(rz_ff));
   assign thr_w = -$signed(SUM_W'({chunk_size, 15'b0}));
   assign cull_in = sum_w < thr_w;

   always_ff @(posedge clock) begin
      if (adv.adv3) begin
         cull_ff <= cull_in;
      end
   end

   assign cull = cull_ff;

endmodule

// ===== sv/fcl_lod_unit.sv =====
// horizontal distance to camera: differences in stage 2, squares in stage 3,
// class from the summed squares for the output stage; depends on fcl_pkg
module fcl_lod_unit #(
   parameter int FRAC_BITS = fcl_pkg::FRAC_BITS
) (
   input  logic                            clock,
   input  fcl_pkg::fcl_adv_type            adv,
   input  logic [31:0]                     camera_xz,
   input  logic signed [fcl_pkg::CENTER_W-1:0] cx2,
   input  logic signed [fcl_pkg::CENTER_W-1:0] cz2,
   output fcl_pkg::lod_type                lod
);
   import fcl_pkg::*;

   // doubled class distances and their squares
   localparam longint FAR2 = longint'(800 << FRAC_BITS);
   localparam longint MID2 = longint'(400 << FRAC_BITS);
   localparam logic [SQSUM_W-1:0] FAR_SQ = SQSUM_W'(FAR2 * FAR2);
   localparam logic [SQSUM_W-1:0] MID_SQ = SQSUM_W'(MID2 * MID2);

   logic signed [16:0] cam_x2, cam_z2;
   logic signed [DIFF_W-1:0] dx_in, dx_ff, dz_in, dz_ff;
   logic signed [2*DIFF_W-1:0] sqx_full, sqz_full;
   logic [SQ_W-1:0] sqx_ff, sqz_ff;
   logic [SQSUM_W-1:0] sq_w;

   assign cam_x2 = $signed({camera_xz[15:0], 1'b0});
   assign cam_z2 = $signed({camera_xz[31:16], 1'b0});
   assign dx_in = DIFF_W'(cx2) - DIFF_W'(cam_x2);
   assign dz_in = DIFF_W'(cz2) - DIFF_W'(cam_z2);

   always_ff @(posedge clock) begin
      if (adv.adv2) begin
         dx_ff <= dx_in;
         dz_ff <= dz_in;
      end
   end

   assign sqx_full = (2*DIFF_W)'(dx_ff) * (2*DIFF_W)'(dx_ff);
   assign sqz_full = (2*DIFF_W)'(dz_ff) * (2*DIFF_W)'(dz_ff);

   always_ff @(posedge clock) begin
      if (adv.adv3) begin
         sqx_ff <= sqx_full[SQ_W-1:0];
         sqz_ff <= sqz_full[SQ_W-1:0];
      end
   end

   assign sq_w = SQSUM_W'(sqx_ff) + SQSUM_W'(sqz_ff);

   // strict compares, so exactly 200 or 400 lands in the finer class
   always_comb begin
      if (sq_w > FAR_SQ) begin
         lod = LOD_QUARTER;
      end else if (sq_w > MID_SQ) begin
         lod = LOD_HALF;
      end else begin
         lod = LOD_FULL;
      end
   end

endmodule

// ===== sv/chunk_frustum_cull_lod_select_unit.sv =====
// top level of the chunk frustum cull and level-of-detail select block
// depends on fcl_pkg, fcl_plane_unit and fcl_lod_unit
//
// Usage:
//   req_ channel: one request per chunk, column and row index of the grid.
//   rsp_ channel: one result per request, in order, echoing column and row
//   with the detail class (culled, full, half, quarter).
//   csr_ channel: register writes (six planes, camera x/z, chunk geometry),
//   always ready; write only while no request is in flight.
// Pipeline: four register stages from request accept to rsp_valid:
//   chunk centers, plane and distance products, per-plane sums and
//   squares, then the combine into the output register.
// Throughput: one request per cycle when not stalled; the widest paths are a 16x24
//   multiply in the product stage and a 25x25 square beside a six-term 44-bit sum.
// Stalls: each stage holds while the one after it is full and blocked, so
//   a stalled rsp_ready backs up into req_ready without losing or repeating
//   a request; empty stages keep filling behind the stall.
// Reset: empties the pipeline and clears the configuration registers to
//   zero, which makes every in-grid chunk visible until planes are written.
module chunk_frustum_cull_lod_select_unit #(
   parameter int CHUNKS_PER_SIDE = fcl_pkg::CHUNKS_PER_SIDE,
   parameter int FRAC_BITS       = fcl_pkg::FRAC_BITS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [5:0]  req_col_index,
   input  logic [5:0]  req_row_index,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [5:0]  rsp_col_out,
   output logic [5:0]  rsp_row_out,
   output logic [1:0]  rsp_lod_class,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wdata
);
   import fcl_pkg::*;

   logic [63:0] plane_ff [NUM_PLANES];
   logic [31:0] camera_ff, geom_ff;
   logic [15:0] chunk_size, origin_off;

   logic adv1, adv4;
   fcl_adv_type adv;

   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic [IDX_W-1:0] col1_ff, row1_ff, col2_ff, row2_ff, col3_ff, row3_ff;
   logic oob1_ff, oob2_ff, oob3_ff;
   logic signed [CENTER_W-1:0] cx2_in, cz2_in, cx2_ff, cz2_ff;
   logic oob_in;

   logic [NUM_PLANES-1:0] cull_w;
   lod_type dist_lod;
   lod_type lod_in;
   logic [IDX_W-1:0] col4_ff, row4_ff;
   lod_type lod4_ff;

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_PLANES; i++) begin
            plane_ff[i] <= '0;
         end
         camera_ff <= '0;
         geom_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_PLANE_LEFT, CSR_PLANE_TOP, CSR_PLANE_RIGHT,
            CSR_PLANE_BOTTOM, CSR_PLANE_NEAR, CSR_PLANE_FAR: begin
               plane_ff[csr_index] <= csr_wdata;
            end
            CSR_CAMERA_XZ: begin
               camera_ff <= csr_wdata[31:0];
            end
            CSR_CHUNK_GEOM: begin
               geom_ff <= csr_wdata[31:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign chunk_size = geom_ff[15:0];
   assign origin_off = geom_ff[31:16];

   // stage advance, each stage loads when it is empty or its successor moves
   assign adv4 = !v4_ff || rsp_ready;
   assign adv.adv3 = !v3_ff || adv4;
   assign adv.adv2 = !v2_ff || adv.adv3;
   assign adv1 = !v1_ff || adv.adv2;
   assign req_ready = adv1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (adv1) v1_ff <= req_valid;
         if (adv.adv2) v2_ff <= v1_ff;
         if (adv.adv3) v3_ff <= v2_ff;
         if (adv4) v4_ff <= v3_ff;
      end
   end

   // stage 1: doubled box centers and grid range check
   assign cx2_in = fcl_center2(req_col_index, chunk_size, origin_off);
   assign cz2_in = fcl_center2(req_row_index, chunk_size, origin_off);
   assign oob_in = (11'(req_col_index) >= 11'(CHUNKS_PER_SIDE))
                || (11'(req_row_index) >= 11'(CHUNKS_PER_SIDE));

   always_ff @(posedge clock) begin
      if (adv1) begin
         col1_ff <= req_col_index;
         row1_ff <= req_row_index;
         cx2_ff <= cx2_in;
         cz2_ff <= cz2_in;
         oob1_ff <= oob_in;
      end
   end

   // stages 2 and 3 carry the echo fields alongside the plane and lod units
   always_ff @(posedge clock) begin
      if (adv.adv2) begin
         col2_ff <= col1_ff;
         row2_ff <= row1_ff;
         oob2_ff <= oob1_ff;
      end
      if (adv.adv3) begin
         col3_ff <= col2_ff;
         row3_ff <= row2_ff;
         oob3_ff <= oob2_ff;
      end
   end

   for (genvar p = 0; p < NUM_PLANES; p++) begin : g_plane
      fcl_plane_unit #(
         .FRAC_BITS (FRAC_BITS)
      ) u_plane (
         .clock      (clock),
         .adv        (adv),
         .plane      (plane_ff[p]),
         .chunk_size (chunk_size),
         .cx2        (cx2_ff),
         .cz2        (cz2_ff),
         .cull       (cull_w[p])
      );
   end

   fcl_lod_unit #(
      .FRAC_BITS (FRAC_BITS)
   ) u_lod (
      .clock     (clock),
      .adv       (adv),
      .camera_xz (camera_ff),
      .cx2       (cx2_ff),
      .cz2       (cz2_ff),
      .lod       (dist_lod)
   );

   // stage 4: combine into the output register
   assign lod_in = (oob3_ff || (|cull_w)) ? LOD_CULLED : dist_lod;

   always_ff @(posedge clock) begin
      if (adv4) begin
         col4_ff <= col3_ff;
         row4_ff <= row3_ff;
         lod4_ff <= lod_in;
      end
   end

   assign rsp_valid = v4_ff;
   assign rsp_col_out = col4_ff;
   assign rsp_row_out = row4_ff;
   assign rsp_lod_class = lod4_ff;

endmodule
